// File: design/josg_pkg.sv
package josg_pkg;

  localparam int HystStepsDef     = 400;
  localparam int MinRangeStepsDef = 800;
  localparam int BasePeriodDef    = 4;
  localparam int RapidPeriodDef   = 1;

  localparam int CfgAddrW = 5;

  typedef enum logic [2:0] {
    REG_X_LO     = 3'd0,
    REG_X_HI     = 3'd1,
    REG_Z_LO     = 3'd2,
    REG_Z_HI     = 3'd3,
    REG_TAUGHT   = 3'd4,
    REG_Z_PASS   = 3'd5,
    REG_X_PASS   = 3'd6,
    REG_INFEED   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_PERIOD,
    ST_DECIDE,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scale;
    logic period;
    logic decide;
  } josg_cmd_t;

  typedef struct packed {
    logic div_done;
  } josg_sts_t;

  typedef struct packed {
    logic        hold_for_manual;
    logic        auto_oscillate;
    logic        stick_up;
    logic        stick_down;
    logic        stick_left;
    logic        stick_right;
    logic        rapid;
    logic [11:0] feed_override;
  } in_item_t;

  typedef struct packed {
    logic               x_step;
    logic               x_dir;
    logic               z_step;
    logic               z_dir;
    logic signed [31:0] x_pos_out;
    logic signed [31:0] z_pos_out;
  } out_item_t;

endpackage

// File: design/josg_if.sv
interface josg_in_if import josg_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface josg_out_if import josg_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/josg_ctrl.sv
module josg_ctrl import josg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output josg_cmd_t cmd,
  input  josg_sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_PERIOD;
      end
      ST_PERIOD: begin
        cmd.period = 1'b1;
        if (sts.div_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: design/josg_dp.sv
module josg_dp import josg_pkg::*; #(
  parameter int HYST_STEPS      = HystStepsDef,
  parameter int MIN_RANGE_STEPS = MinRangeStepsDef,
  parameter int BASE_PERIOD     = BasePeriodDef,
  parameter int RAPID_PERIOD    = RapidPeriodDef
) (
  input  logic                clk,
  input  logic                rst,
  input  josg_cmd_t           cmd,
  output josg_sts_t           sts,
  input  in_item_t            item,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [31:0]         cfg_wdata,
  output logic [31:0]         cfg_rdata,
  output out_item_t           result
);

  localparam logic [15:0] BaseNum  = 16'(BASE_PERIOD * 100);
  localparam logic [15:0] RapidNum = 16'(RAPID_PERIOD * 100);

  logic [31:0] lim [4];
  logic [1:0]  taught;
  logic [6:0]  z_pass, x_pass;
  logic [15:0] infeed;

  logic [31:0] tick_count, last_step_tick, x_position, z_position;
  logic [31:0] x_total, z_total, infeed_pending;
  logic        x_auto_dir, z_auto_dir;
  logic [15:0] x_rev, z_rev;

  in_item_t    it;
  logic [7:0]  scale;
  logic [15:0] rem;
  logic [15:0] quo;
  logic [4:0]  dcnt;
  logic        x_step, x_dir, z_step, z_dir;

  // config writes and reads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) lim[i] <= '0;
      taught <= '0;
      z_pass <= '0;
      x_pass <= '0;
      infeed <= '0;
    end else if (cfg_we) begin
      case (cfg_addr[4:2])
        REG_X_LO:   lim[0] <= cfg_wdata;
        REG_X_HI:   lim[1] <= cfg_wdata;
        REG_Z_LO:   lim[2] <= cfg_wdata;
        REG_Z_HI:   lim[3] <= cfg_wdata;
        REG_TAUGHT: taught <= cfg_wdata[1:0];
        REG_Z_PASS: z_pass <= cfg_wdata[6:0];
        REG_X_PASS: x_pass <= cfg_wdata[6:0];
        REG_INFEED: infeed <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_addr[4:2])
      REG_X_LO:   cfg_rdata = lim[0];
      REG_X_HI:   cfg_rdata = lim[1];
      REG_Z_LO:   cfg_rdata = lim[2];
      REG_Z_HI:   cfg_rdata = lim[3];
      REG_TAUGHT: cfg_rdata = {30'd0, taught};
      REG_Z_PASS: cfg_rdata = {25'd0, z_pass};
      REG_X_PASS: cfg_rdata = {25'd0, x_pass};
      REG_INFEED: cfg_rdata = {16'd0, infeed};
      default:    cfg_rdata = '0;
    endcase
  end

  // scale = 30 + fo*120/4095 by reciprocal multiply then correction
  // the reciprocal is slightly high, so the estimate is exact or one over
  logic [19:0] fo120;
  logic [7:0]  q_raw;
  logic [7:0]  q_est;
  logic [20:0] q_prod;
  always_comb begin
    fo120  = 20'(it.feed_override) * 20'd120;
    q_raw  = 8'(({12'd0, fo120} * 32'd1025) >> 22);
    q_prod = 21'(q_raw) * 21'd4095;
    q_est  = (q_prod > 21'(fo120)) ? q_raw - 8'd1 : q_raw;
  end

  // restoring divide, one quotient bit a cycle
  logic [16:0] trial;
  always_comb trial = {rem[15:0], quo[15]} - {9'd0, scale};

  assign sts.div_done = (dcnt == 5'd16);

  // auto axis evaluation
  typedef struct packed {
    logic        go;
    logic        dir;
    logic [15:0] rev;
    logic        add_infeed;
  } ax_t;

  function automatic ax_t auto_axis(logic [31:0] lo_r, logic [31:0] hi_r,
                                    logic [31:0] pos, logic [6:0] pl,
                                    logic dir, logic [15:0] rev, logic is_z);
    logic signed [33:0] lo, hi, p;
    ax_t r;
    lo = 34'(signed'(lo_r));
    hi = 34'(signed'(hi_r));
    p  = 34'(signed'(pos));
    r.go = 1'b0; r.dir = dir; r.rev = rev; r.add_infeed = 1'b0;
    if (lo > hi) begin
      lo = 34'(signed'(hi_r));
      hi = 34'(signed'(lo_r));
    end
    if ((hi - lo) >= 34'(MIN_RANGE_STEPS) &&
        !(pl != 7'd0 && {1'b0, rev} >= {9'd0, pl, 1'b0})) begin
      r.go = 1'b1;
      if (p >= hi - 34'(HYST_STEPS)) r.dir = 1'b0;
      else if (p <= lo + 34'(HYST_STEPS)) r.dir = 1'b1;
      if (r.dir != dir) begin
        r.rev = rev + 16'd1;
        if (is_z && r.rev >= 16'd2 && !r.rev[0] && infeed != 16'd0)
          r.add_infeed = 1'b1;
      end
    end
    return r;
  endfunction

  ax_t         zr, xr;
  logic [32:0] inf_sum;
  always_comb begin
    zr = auto_axis(lim[2], lim[3], z_position, z_pass, z_auto_dir, z_rev, 1'b1);
    xr = auto_axis(lim[0], lim[1], x_position, x_pass, x_auto_dir, x_rev, 1'b0);
    inf_sum = {1'b0, infeed_pending} + {17'd0, infeed};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0; last_step_tick <= '0;
      x_position <= '0; z_position <= '0;
      x_total <= '0; z_total <= '0; infeed_pending <= '0;
      x_auto_dir <= 1'b1; z_auto_dir <= 1'b1;
      x_rev <= '0; z_rev <= '0;
      x_step <= 1'b0; x_dir <= 1'b0; z_step <= 1'b0; z_dir <= 1'b0;
      dcnt <= '0;
    end else begin
      if (cmd.load) begin
        it <= item;
        x_step <= 1'b0; x_dir <= 1'b0; z_step <= 1'b0; z_dir <= 1'b0;
        if (!item.hold_for_manual) tick_count <= tick_count + 32'd1;
      end
      if (cmd.scale) begin
        scale <= 8'd30 + q_est;
        rem   <= '0;
        quo   <= it.rapid ? RapidNum : BaseNum;
        dcnt  <= '0;
      end
      if (cmd.period && !sts.div_done) begin
        if (!trial[16]) begin
          rem <= trial[15:0];
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= {rem[14:0], quo[15]};
          quo <= {quo[14:0], 1'b0};
        end
        dcnt <= dcnt + 5'd1;
      end
      if (cmd.decide && !it.hold_for_manual &&
          (tick_count - last_step_tick) >= ((quo == 16'd0) ? 32'd1 : {16'd0, quo})) begin
        last_step_tick <= tick_count;
        if (it.auto_oscillate) begin
          if (infeed_pending != 32'd0) begin
            infeed_pending <= infeed_pending - 32'd1;
            x_step <= 1'b1; x_dir <= 1'b0;
            x_total <= x_total + 32'd1; x_position <= x_position - 32'd1;
          end else if (it.stick_up || it.stick_down) begin
            if (taught[1]) begin
              z_auto_dir <= zr.dir;
              z_rev <= zr.rev;
              if (zr.add_infeed)
                infeed_pending <= inf_sum[32] ? '1 : inf_sum[31:0];
              if (zr.go) begin
                z_step <= 1'b1; z_dir <= zr.dir; z_total <= z_total + 32'd1;
                z_position <= zr.dir ? z_position + 32'd1 : z_position - 32'd1;
              end
            end else begin
              z_step <= 1'b1; z_dir <= it.stick_up; z_total <= z_total + 32'd1;
              z_position <= it.stick_up ? z_position + 32'd1 : z_position - 32'd1;
            end
          end else if (it.stick_left || it.stick_right) begin
            if (taught[0]) begin
              x_auto_dir <= xr.dir;
              x_rev <= xr.rev;
              if (xr.go) begin
                x_step <= 1'b1; x_dir <= xr.dir; x_total <= x_total + 32'd1;
                x_position <= xr.dir ? x_position + 32'd1 : x_position - 32'd1;
              end
            end else begin
              x_step <= 1'b1; x_dir <= !it.stick_left; x_total <= x_total + 32'd1;
              x_position <= it.stick_left ? x_position - 32'd1 : x_position + 32'd1;
            end
          end else begin
            x_rev <= '0; z_rev <= '0;
          end
        end else if (it.stick_up || it.stick_down) begin
          z_step <= 1'b1; z_dir <= it.stick_up; z_total <= z_total + 32'd1;
          z_position <= it.stick_up ? z_position + 32'd1 : z_position - 32'd1;
        end else if (it.stick_left || it.stick_right) begin
          x_step <= 1'b1; x_dir <= !it.stick_left; x_total <= x_total + 32'd1;
          x_position <= it.stick_left ? x_position - 32'd1 : x_position + 32'd1;
        end
      end
    end
  end

  assign result.x_step    = x_step;
  assign result.x_dir     = x_dir;
  assign result.z_step    = z_step;
  assign result.z_dir     = z_dir;
  assign result.x_pos_out = x_position;
  assign result.z_pos_out = z_position;

endmodule

// File: design/jog_oscillate_step_generator.sv
// result: after the input transfer the block runs scale, 16 divide iterations
//   and a done check, then decide; the result is held until transferred
// input: a new item is taken only in idle, after the last result is transferred
// reset: rst synchronous active high; config and counters zero, auto directions plus
module jog_oscillate_step_generator import josg_pkg::*; #(
  parameter int HYST_STEPS      = HystStepsDef,
  parameter int MIN_RANGE_STEPS = MinRangeStepsDef,
  parameter int BASE_PERIOD     = BasePeriodDef,
  parameter int RAPID_PERIOD    = RapidPeriodDef
) (
  input  logic                clk,
  input  logic                rst,
  josg_in_if.sink             in_ch,
  josg_out_if.source          out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  josg_cmd_t cmd;
  josg_sts_t sts;

  // apb write lands in the access phase
  assign pready = 1'b1;

  josg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  josg_dp #(
    .HYST_STEPS      (HYST_STEPS),
    .MIN_RANGE_STEPS (MIN_RANGE_STEPS),
    .BASE_PERIOD     (BASE_PERIOD),
    .RAPID_PERIOD    (RAPID_PERIOD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .item      (in_ch.data),
    .cfg_we    (psel & penable & pwrite),
    .cfg_addr  (paddr),
    .cfg_wdata (pwdata),
    .cfg_rdata (prdata),
    .result    (out_ch.data)
  );

endmodule
